@@ hw/rtl/rfto_pkg.sv @@
// ----------------------------------------------------------------------------
// rfto_pkg
// Shared types and constants of the formation target optimizer.
// ----------------------------------------------------------------------------
package rfto_pkg;

    localparam int APB_AW = 5;

    // Register indexes on the configuration port (word address)
    localparam logic [2:0] REG_ITER_COUNT = 3'd0;
    localparam logic [2:0] REG_GROW       = 3'd1;
    localparam logic [2:0] REG_SHRINK     = 3'd2;
    localparam logic [2:0] REG_CEILING    = 3'd3;
    localparam logic [2:0] REG_FLOOR      = 3'd4;

    localparam logic [6:0]  RST_ITER_COUNT = 7'd25;
    localparam logic [18:0] RST_GROW       = 19'd78643;
    localparam logic [16:0] RST_SHRINK     = 17'd32768;
    localparam logic [20:0] RST_CEILING    = 21'd65536;
    localparam logic [20:0] RST_FLOOR      = 21'd0;
    localparam logic [31:0] RST_STEP       = 32'd32768;

    // ceil(2^32 / 7): exact quotient by 7 for dividends below 2^23
    localparam logic [31:0] DIV7_RECIP  = 32'd613566757;
    // Gaussian argument of 16.0 or more gives a zero factor
    localparam logic [32:0] EXP_ARG_MAX = 33'd7340032;
    localparam logic [31:0] MAG_CLIP    = 32'd16777216;

    // Center codes
    localparam logic [1:0] CTR_FIRST  = 2'd0;
    localparam logic [1:0] CTR_SECOND = 2'd1;
    localparam logic [1:0] CTR_GOAL   = 2'd2;

    typedef enum logic [1:0] {
        SG_ZERO,
        SG_POS,
        SG_NEG
    } t_sgn;

    typedef struct packed {
        logic [6:0]  iteration_count;
        logic [18:0] grow_factor;
        logic [16:0] shrink_factor;
        logic [20:0] step_ceiling;
        logic [20:0] step_floor;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] own_x;
        logic signed [31:0] own_y;
        logic signed [31:0] first_neighbor_x;
        logic signed [31:0] first_neighbor_y;
        logic signed [31:0] second_neighbor_x;
        logic signed [31:0] second_neighbor_y;
        logic signed [31:0] goal_point_x;
        logic signed [31:0] goal_point_y;
    } t_item;

    function automatic logic [31:0] mag33(logic signed [32:0] d);
        logic [32:0] n;
        n = d[32] ? (~d + 33'd1) : d;
        return n[31:0];
    endfunction

    function automatic logic signed [31:0] sat34(logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic t_sgn sgn38(logic signed [37:0] v);
        t_sgn s;
        if (v == 38'sd0) begin
            s = SG_ZERO;
        end else if (v[37]) begin
            s = SG_NEG;
        end else begin
            s = SG_POS;
        end
        return s;
    endfunction

endpackage

@@ hw/rtl/rfto_mul.sv @@
// ----------------------------------------------------------------------------
// rfto_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module rfto_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {32'd0, i_a} * {32'd0, i_b};
    end

    assign o_p = r_p;

endmodule

@@ hw/rtl/rfto_exp_rom.sv @@
// ----------------------------------------------------------------------------
// rfto_exp_rom
// Constant table of e^(-16 i / depth) in Q2.30, one registered read a cycle.
// ----------------------------------------------------------------------------
module rfto_exp_rom #(
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic [$clog2(EXP_TABLE_DEPTH+1)-1:0] i_addr,
    output logic [31:0]                          o_data
);
    localparam logic [63:0] STEP_H = (64'd1 << 34) / EXP_TABLE_DEPTH;

    typedef logic [31:0] t_lut [0:EXP_TABLE_DEPTH];

    // Ratio from a truncated Taylor series, then a rounded running product
    function automatic t_lut build_lut();
        t_lut        lut;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] e;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int n = 1; n <= 24; n++) begin
            term = ((term * STEP_H) >> 30) / 64'(n);
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        e      = 64'd1 << 30;
        lut[0] = e[31:0];
        for (int i = 1; i <= EXP_TABLE_DEPTH; i++) begin
            e      = (e * sum + (64'd1 << 29)) >> 30;
            lut[i] = e[31:0];
        end
        return lut;
    endfunction

    localparam t_lut EXP_LUT = build_lut();

    logic [31:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= EXP_LUT[i_addr];
    end

    assign o_data = r_data;

endmodule

@@ hw/rtl/rfto_core.sv @@
// ----------------------------------------------------------------------------
// rfto_core
// Sequencer and datapath: cost and gradient evaluation plus step update,
// all multiplies through one shared multiplier.
// ----------------------------------------------------------------------------
module rfto_core #(
    parameter int EXP_TABLE_DEPTH = 256,
    parameter int MAX_ITERATIONS  = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rfto_pkg::t_cfg        i_cfg,
    input  logic                  i_start,
    input  rfto_pkg::t_item       i_item,
    output logic                  o_busy,
    output logic                  o_valid,
    output logic signed [31:0]    o_move_to_x,
    output logic signed [31:0]    o_move_to_y
);
    import rfto_pkg::*;

    localparam int CW = $clog2(MAX_ITERATIONS + 1);
    localparam int AW = $clog2(EXP_TABLE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_EVAL, S_QUAD, S_QACC, S_SQ, S_DIVA, S_DEPTH, S_ROMLO, S_ROMHI,
        S_INTERP, S_EXPV, S_GMUL, S_GACC, S_BMUL, S_BY, S_BHI, S_BLO, S_BACC,
        S_EVEND, S_UMUL, S_USTEP, S_UMOVE, S_DONE
    } t_state;

    t_state r_state;

    logic signed [31:0] r_wx, r_wy, r_pwx, r_pwy;
    logic signed [31:0] r_n1x, r_n1y, r_n2x, r_n2y, r_glx, r_gly;
    logic [31:0]        r_dsx, r_dsy, r_dprev;
    logic signed [51:0] r_cost, r_cprev;
    logic signed [37:0] r_gx, r_gy;
    t_sgn               r_gpx, r_gpy, r_cls;
    logic [CW-1:0]      r_iter, r_n;
    logic               r_first, r_axis, r_valid;
    logic [1:0]         r_k, r_qi;
    logic [AW-1:0]      r_idx;
    logic [15:0]        r_frac, r_qh;
    logic [31:0]        r_lo;
    logic [16:0]        r_ex, r_ey, r_g;
    logic [35:0]        r_y;
    logic signed [31:0] r_mx, r_my;

    logic [31:0]   mul_a, mul_b;
    logic [63:0]   prod;
    logic [AW-1:0] rom_addr;
    logic [31:0]   rom_q;

    rfto_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    rfto_exp_rom #(
        .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_q)
    );

    // Offset from the current center on the current axis
    logic signed [31:0] wa, ca;
    logic signed [32:0] d_c;
    logic [31:0]        m_c, mc;
    logic               d_neg;

    always_comb begin
        wa = r_axis ? r_wy : r_wx;
        case (r_k)
            CTR_FIRST:  ca = r_axis ? r_n1y : r_n1x;
            CTR_SECOND: ca = r_axis ? r_n2y : r_n2x;
            default:    ca = r_axis ? r_gly : r_glx;
        endcase
        d_c   = {wa[31], wa} - {ca[31], ca};
        m_c   = mag33(d_c);
        d_neg = d_c[32];
        mc    = (m_c > MAG_CLIP) ? MAG_CLIP : m_c;
    end

    // Offsets of the quadratic terms
    logic signed [32:0] d_q;
    logic [31:0]        m_q;

    always_comb begin
        case (r_qi)
            2'd0:    d_q = {r_wx[31], r_wx} - {r_pwx[31], r_pwx};
            2'd1:    d_q = {r_wy[31], r_wy} - {r_pwy[31], r_pwy};
            2'd2:    d_q = {r_wx[31], r_wx} - {r_glx[31], r_glx};
            default: d_q = {r_wy[31], r_wy} - {r_gly[31], r_gly};
        endcase
        m_q = mag33(d_q);
    end

    // Linear gradient terms at the start of an evaluation
    logic signed [32:0] lx0, lx1, ly0, ly1;
    assign lx0 = {r_wx[31], r_wx} - {r_pwx[31], r_pwx};
    assign lx1 = {r_wx[31], r_wx} - {r_glx[31], r_glx};
    assign ly0 = {r_wy[31], r_wy} - {r_pwy[31], r_pwy};
    assign ly1 = {r_wy[31], r_wy} - {r_gly[31], r_gly};

    // Interpolated exponential, rounded to Q1.16
    logic [31:0] ev_v, ev_r;
    logic [16:0] ev;
    assign ev_v = r_lo - {1'b0, prod[46:16]};
    assign ev_r = ev_v + 32'd8192;
    assign ev   = ev_r[30:14];

    // Bump: 10 * g * m / 2^16, then divide by 7 in two halves
    logic [51:0] y10;
    logic [18:0] qh7, rh_full;
    assign y10     = {1'b0, prod[47:0], 3'b000} + {3'b000, prod[47:0], 1'b0};
    assign qh7     = {prod[47:32], 3'b000} - {3'b000, prod[47:32]};
    assign rh_full = {1'b0, r_y[35:18]} - qh7;

    logic [33:0]        bump_t;
    logic signed [37:0] grad_a, bump_s;
    assign bump_t = {r_qh, prod[49:32]};
    assign grad_a = r_axis ? r_gy : r_gx;
    assign bump_s = (((r_k != CTR_GOAL) ^ d_neg) ? -$signed({4'd0, bump_t})
                                                 :  $signed({4'd0, bump_t}));

    logic [16:0]        g_v;
    logic [18:0]        g5;
    assign g_v = prod[32:16];
    assign g5  = {g_v, 2'b00} + {2'b00, g_v};

    // Step update on the current axis
    t_sgn        sc, sp, cls;
    logic [31:0] ds_a, s_sc;
    logic [18:0] fac;

    always_comb begin
        sc   = sgn38(grad_a);
        sp   = r_axis ? r_gpy : r_gpx;
        ds_a = r_axis ? r_dsy : r_dsx;
        if ((sp == SG_POS && sc == SG_POS) || (sp == SG_NEG && sc == SG_NEG)) begin
            cls = SG_POS;
        end else if ((sp == SG_POS && sc == SG_NEG) || (sp == SG_NEG && sc == SG_POS)) begin
            cls = SG_NEG;
        end else begin
            cls = SG_ZERO;
        end
        fac  = (cls == SG_POS) ? i_cfg.grow_factor : {2'b00, i_cfg.shrink_factor};
        s_sc = (prod[50:48] != 3'd0) ? 32'hFFFF_FFFF : prod[47:16];
    end

    logic signed [33:0] w_ext, w_fwd, w_back;
    logic signed [31:0] w_a;
    always_comb begin
        w_a    = r_axis ? r_wy : r_wx;
        w_ext  = {{2{w_a[31]}}, w_a};
        // Fresh step, direction opposite to the steering gradient sign
        if ((r_cls == SG_POS && sc == SG_NEG) || (r_cls == SG_ZERO && sp == SG_NEG)) begin
            w_fwd = w_ext + $signed({2'b00, ds_a});
        end else begin
            w_fwd = w_ext - $signed({2'b00, ds_a});
        end
        // Backtrack by the previous step
        if (sp == SG_NEG) begin
            w_back = w_ext - $signed({2'b00, r_dprev});
        end else begin
            w_back = w_ext + $signed({2'b00, r_dprev});
        end
    end

    // Multiplier operand and table address select
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            S_QUAD: begin
                mul_a = m_q;
                mul_b = m_q;
            end
            S_SQ: begin
                mul_a = mc;
                mul_b = mc;
            end
            S_DIVA: begin
                mul_a = {9'd0, prod[38:16]};
                mul_b = DIV7_RECIP;
            end
            S_DEPTH: begin
                mul_a = {12'd0, prod[51:32]};
                mul_b = 32'(EXP_TABLE_DEPTH);
            end
            S_INTERP: begin
                mul_a = r_lo - rom_q;
                mul_b = {16'd0, r_frac};
            end
            S_GMUL: begin
                mul_a = {15'd0, r_ex};
                mul_b = {15'd0, r_ey};
            end
            S_BMUL: begin
                mul_a = {15'd0, r_g};
                mul_b = m_c;
            end
            S_BHI: begin
                mul_a = {14'd0, r_y[35:18]};
                mul_b = DIV7_RECIP;
            end
            S_BLO: begin
                mul_a = {11'd0, rh_full[2:0], r_y[17:0]};
                mul_b = DIV7_RECIP;
            end
            S_UMUL: begin
                mul_a = ds_a;
                mul_b = {13'd0, fac};
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
        case (r_state)
            S_ROMLO: rom_addr = prod[20 +: AW];
            S_ROMHI: rom_addr = r_idx + 1'b1;
            default: rom_addr = r_idx;
        endcase
    end

    logic [CW-1:0] n_clamp;
    always_comb begin
        if (32'(i_cfg.iteration_count) > MAX_ITERATIONS) begin
            n_clamp = CW'(MAX_ITERATIONS);
        end else begin
            n_clamp = CW'(i_cfg.iteration_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_dsx   <= RST_STEP;
            r_dsy   <= RST_STEP;
            r_iter  <= '0;
            r_n     <= '0;
            r_first <= 1'b0;
            r_axis  <= 1'b0;
            r_k     <= CTR_FIRST;
            r_qi    <= 2'd0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_wx    <= i_item.own_x;
                        r_wy    <= i_item.own_y;
                        r_pwx   <= i_item.own_x;
                        r_pwy   <= i_item.own_y;
                        r_n1x   <= i_item.first_neighbor_x;
                        r_n1y   <= i_item.first_neighbor_y;
                        r_n2x   <= i_item.second_neighbor_x;
                        r_n2y   <= i_item.second_neighbor_y;
                        r_glx   <= i_item.goal_point_x;
                        r_gly   <= i_item.goal_point_y;
                        r_n     <= n_clamp;
                        r_iter  <= '0;
                        r_first <= 1'b1;
                        r_state <= (n_clamp == '0) ? S_DONE : S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_cost  <= 52'sd327680;
                    r_gx    <= 38'(lx0) + 38'(lx1);
                    r_gy    <= 38'(ly0) + 38'(ly1);
                    r_qi    <= 2'd0;
                    r_k     <= CTR_FIRST;
                    r_axis  <= 1'b0;
                    r_state <= S_QUAD;
                end
                S_QUAD: r_state <= S_QACC;
                S_QACC: begin
                    r_cost <= r_cost + $signed({5'd0, prod[63:17]});
                    if (r_qi == 2'd3) begin
                        r_state <= S_SQ;
                    end else begin
                        r_qi    <= r_qi + 2'd1;
                        r_state <= S_QUAD;
                    end
                end
                S_SQ: r_state <= S_DIVA;
                S_DIVA: begin
                    if (prod[48:16] >= EXP_ARG_MAX) begin
                        if (r_axis) begin
                            r_ey    <= 17'd0;
                            r_state <= S_GMUL;
                        end else begin
                            r_ex    <= 17'd0;
                            r_axis  <= 1'b1;
                            r_state <= S_SQ;
                        end
                    end else begin
                        r_state <= S_DEPTH;
                    end
                end
                S_DEPTH: r_state <= S_ROMLO;
                S_ROMLO: begin
                    r_idx   <= prod[20 +: AW];
                    r_frac  <= prod[19:4];
                    r_state <= S_ROMHI;
                end
                S_ROMHI: begin
                    r_lo    <= rom_q;
                    r_state <= S_INTERP;
                end
                S_INTERP: r_state <= S_EXPV;
                S_EXPV: begin
                    if (r_axis) begin
                        r_ey    <= ev;
                        r_state <= S_GMUL;
                    end else begin
                        r_ex    <= ev;
                        r_axis  <= 1'b1;
                        r_state <= S_SQ;
                    end
                end
                S_GMUL: r_state <= S_GACC;
                S_GACC: begin
                    r_g <= g_v;
                    if (r_k == CTR_GOAL) begin
                        r_cost <= r_cost - $signed({33'd0, g5});
                    end else begin
                        r_cost <= r_cost + $signed({33'd0, g5});
                    end
                    r_axis  <= 1'b0;
                    r_state <= S_BMUL;
                end
                S_BMUL: r_state <= S_BY;
                S_BY: begin
                    r_y     <= y10[51:16];
                    r_state <= S_BHI;
                end
                S_BHI: r_state <= S_BLO;
                S_BLO: begin
                    r_qh    <= prod[47:32];
                    r_state <= S_BACC;
                end
                S_BACC: begin
                    if (r_axis) begin
                        r_gy <= r_gy + bump_s;
                    end else begin
                        r_gx <= r_gx + bump_s;
                    end
                    if (!r_axis) begin
                        r_axis  <= 1'b1;
                        r_state <= S_BMUL;
                    end else if (r_k == CTR_GOAL) begin
                        r_axis  <= 1'b0;
                        r_state <= S_EVEND;
                    end else begin
                        r_axis  <= 1'b0;
                        r_k     <= r_k + 2'd1;
                        r_state <= S_SQ;
                    end
                end
                S_EVEND: begin
                    // First pass: the previous gradient is the one just taken
                    if (r_first) begin
                        r_gpx   <= sgn38(r_gx);
                        r_gpy   <= sgn38(r_gy);
                        r_cprev <= r_cost;
                        r_first <= 1'b0;
                    end
                    r_state <= S_UMUL;
                end
                S_UMUL: begin
                    r_cls   <= cls;
                    r_dprev <= ds_a;
                    r_state <= S_USTEP;
                end
                S_USTEP: begin
                    if (r_cls == SG_POS) begin
                        if (r_axis) begin
                            r_dsy <= (s_sc < {11'd0, i_cfg.step_ceiling}) ? s_sc
                                   : {11'd0, i_cfg.step_ceiling};
                        end else begin
                            r_dsx <= (s_sc < {11'd0, i_cfg.step_ceiling}) ? s_sc
                                   : {11'd0, i_cfg.step_ceiling};
                        end
                    end else if (r_cls == SG_NEG) begin
                        if (r_axis) begin
                            r_dsy <= (s_sc > {11'd0, i_cfg.step_floor}) ? s_sc
                                   : {11'd0, i_cfg.step_floor};
                        end else begin
                            r_dsx <= (s_sc > {11'd0, i_cfg.step_floor}) ? s_sc
                                   : {11'd0, i_cfg.step_floor};
                        end
                    end
                    r_state <= S_UMOVE;
                end
                S_UMOVE: begin
                    if (r_cls != SG_NEG) begin
                        if (r_axis) begin
                            r_pwy <= r_wy;
                            r_wy  <= sat34(w_fwd);
                            r_gpy <= sc;
                        end else begin
                            r_pwx <= r_wx;
                            r_wx  <= sat34(w_fwd);
                            r_gpx <= sc;
                        end
                    end else begin
                        if (r_axis) begin
                            if (r_cost > r_cprev) begin
                                r_pwy <= r_wy;
                                r_wy  <= sat34(w_back);
                            end
                            r_gpy <= SG_ZERO;
                        end else begin
                            if (r_cost > r_cprev) begin
                                r_pwx <= r_wx;
                                r_wx  <= sat34(w_back);
                            end
                            r_gpx <= SG_ZERO;
                        end
                    end
                    if (!r_axis) begin
                        r_axis  <= 1'b1;
                        r_state <= S_UMUL;
                    end else begin
                        r_axis  <= 1'b0;
                        r_cprev <= r_cost;
                        r_iter  <= r_iter + 1'b1;
                        r_state <= (r_iter + 1'b1 == r_n) ? S_DONE : S_EVAL;
                    end
                end
                S_DONE: begin
                    r_mx    <= r_wx;
                    r_my    <= r_wy;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_move_to_x = r_mx;
    assign o_move_to_y = r_my;

endmodule

@@ hw/rtl/rprop_formation_target_optimizer_top.sv @@
// ----------------------------------------------------------------------------
// rprop_formation_target_optimizer_top
// iRPROP+ search for a formation target point on a 2-D Q16.16 cost.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive the eight position fields and raise start; the
//   transaction is taken at a clock edge where start is high and busy low.
//   busy stays high while the search runs.
//   Result channel: o_valid pulses for one cycle with o_move_to_x/y. The
//   receiver cannot stall; a result must be taken in that cycle.
//   Configuration: APB-style port, registers at byte addresses 0,4,..,16
//   (iteration count, grow, shrink, step ceiling, step floor). pready is
//   always high; write only while busy is low.
//   Each Gaussian factor that underflows to zero skips its table lookup.
//   The next command can be taken at the same edge that takes the result;
//   N = 0 returns the own position.
//   One item at a time; every multiply of an iteration goes through one
//   shared 32x32 multiplier.
//   Reset (synchronous, active low) restores the configuration registers
//   to their defaults, the sequencer to idle and the per-axis step sizes to 0.5.
// ----------------------------------------------------------------------------
module rprop_formation_target_optimizer_top #(
    parameter int EXP_TABLE_DEPTH = 256,
    parameter int MAX_ITERATIONS  = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rfto_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // Command channel
    input  logic                           start,
    output logic                           busy,
    input  logic signed [31:0]             i_own_x,
    input  logic signed [31:0]             i_own_y,
    input  logic signed [31:0]             i_first_neighbor_x,
    input  logic signed [31:0]             i_first_neighbor_y,
    input  logic signed [31:0]             i_second_neighbor_x,
    input  logic signed [31:0]             i_second_neighbor_y,
    input  logic signed [31:0]             i_goal_point_x,
    input  logic signed [31:0]             i_goal_point_y,
    // Result channel
    output logic                           o_valid,
    output logic signed [31:0]             o_move_to_x,
    output logic signed [31:0]             o_move_to_y
);
    import rfto_pkg::*;

    t_cfg        r_cfg;
    t_item       item;
    logic        wr_en;
    logic [2:0]  reg_idx;
    logic        core_busy;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // Register writes: take the transaction on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.iteration_count <= RST_ITER_COUNT;
            r_cfg.grow_factor     <= RST_GROW;
            r_cfg.shrink_factor   <= RST_SHRINK;
            r_cfg.step_ceiling    <= RST_CEILING;
            r_cfg.step_floor      <= RST_FLOOR;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ITER_COUNT: r_cfg.iteration_count <= pwdata[6:0];
                REG_GROW:       r_cfg.grow_factor     <= pwdata[18:0];
                REG_SHRINK:     r_cfg.shrink_factor   <= pwdata[16:0];
                REG_CEILING:    r_cfg.step_ceiling    <= pwdata[20:0];
                REG_FLOOR:      r_cfg.step_floor      <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    // Read back, zero outside the map
    always_comb begin
        case (reg_idx)
            REG_ITER_COUNT: prdata = {25'd0, r_cfg.iteration_count};
            REG_GROW:       prdata = {13'd0, r_cfg.grow_factor};
            REG_SHRINK:     prdata = {15'd0, r_cfg.shrink_factor};
            REG_CEILING:    prdata = {11'd0, r_cfg.step_ceiling};
            REG_FLOOR:      prdata = {11'd0, r_cfg.step_floor};
            default:        prdata = 32'd0;
        endcase
    end

    // Gather the command payload
    assign item.own_x             = i_own_x;
    assign item.own_y             = i_own_y;
    assign item.first_neighbor_x  = i_first_neighbor_x;
    assign item.first_neighbor_y  = i_first_neighbor_y;
    assign item.second_neighbor_x = i_second_neighbor_x;
    assign item.second_neighbor_y = i_second_neighbor_y;
    assign item.goal_point_x      = i_goal_point_x;
    assign item.goal_point_y      = i_goal_point_y;

    rfto_core #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
        .MAX_ITERATIONS  (MAX_ITERATIONS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (start),
        .i_item      (item),
        .o_busy      (core_busy),
        .o_valid     (o_valid),
        .o_move_to_x (o_move_to_x),
        .o_move_to_y (o_move_to_y)
    );

    assign busy = core_busy;

endmodule
